>>> hw/rtl/parallel_lcd_bus_master_assert.svh
// Assertion macros shared by the LCD bus master checkers.
`ifndef PARALLEL_LCD_BUS_MASTER_ASSERT_SVH
`define PARALLEL_LCD_BUS_MASTER_ASSERT_SVH

// Plain property, sampled on the rising clock, off while reset is asserted.
`define LCDBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, sampled on the rising clock, off during reset.
`define LCDBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LCDBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lcdbm_pkg.sv
// Types, codes and constants of the parallel LCD bus master.
package lcdbm_pkg;

  // Item kinds; the fourth code is not a kind and is dropped.
  typedef enum logic [1:0] {
    KindCmd  = 2'd0,
    KindData = 2'd1,
    KindRead = 2'd2
  } item_kind_e;

  // Read formats; the fourth code reads one byte.
  typedef enum logic [1:0] {
    FmtByte  = 2'd0,
    FmtWord  = 2'd1,
    FmtPixel = 2'd2
  } read_fmt_e;

  typedef enum logic [1:0] {
    CycWrite = 2'd0,
    CycRead  = 2'd1,
    CycDummy = 2'd2
  } cycle_kind_e;

  // Config register indexes (byte address 4*index).
  localparam int unsigned AddrW = 3;
  localparam logic RegByteSwap = 1'b0;
  localparam logic RegSelHeld  = 1'b1;

  // RGB565 packing masks.
  localparam logic [7:0] RedMask   = 8'b11111000;
  localparam logic [7:0] GreenMask = 8'b11111100;

  localparam int unsigned QueueDepthDef = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word_value;
    logic        wide;
    logic [1:0]  read_format;
    logic [3:0]  dummy_reads;
    logic [23:0] panel_bytes;
    logic        closes;
  } in_item_t;

  typedef struct packed {
    logic        register_select;
    logic [1:0]  cycle_kind;
    logic [7:0]  bus_byte;
    logic        select_active;
    logic [15:0] read_word;
    logic        read_valid;
    logic        released;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic byte_swap;
    logic select_held_low;
  } cfg_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic        is_read;
    logic        rs;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [3:0]  dummies;
    logic [4:0]  total;
    logic [15:0] rword;
    logic        rel;
  } desc_t;

endpackage

>>> hw/rtl/parallel_lcd_bus_master.sv
// Top level of the 8-bit 8080-style parallel LCD bus master.
//
// Items in: push/full queue port carrying in_item_t. An item is taken on a
// rising edge with push high and full low. Kind 3 is taken and dropped.
// Results out: empty/pop queue port carrying out_item_t, one result per bus
// strobe, oldest first; a result is taken on a rising edge with pop high and
// empty low.
// Expansion: command/data writes give 1 or 2 strobes; reads give
// dummy_reads + 1, 2 or 3 strobes (up to 18).
// Path: the first strobe of an item reaches the result port through the
// descriptor queue and then the result register (when the back end is free).
// Throughput: one strobe per clock while results are popped, set by the back
// end sequencer that emits one cycle of the head descriptor per clock. The
// front end takes one item per clock while the descriptor queue has room, so
// items queue up behind a long read.
// Stall: while pop is low the result register holds, the sequencer waits and
// the queue fills; full rises when it has QueueDepth entries.
// Reset: rst_ni (async, active low) empties the queue and result register and
// clears both config registers. Config goes through the APB port with pready
// tied high; byte_swap at 0x0, select_held_low at 0x4.
module parallel_lcd_bus_master import lcdbm_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item side
  input  logic             push,
  output logic             full,
  input  in_item_t         item_i,
  // result side
  output logic             empty,
  input  logic             pop,
  output out_item_t        result_o,
  // config port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg_q, cfg_d;
  desc_t desc, head;
  logic  keep, q_full, q_empty, head_pop;
  logic  reg_idx;

  // ---- config registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1];

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        RegByteSwap: cfg_d.byte_swap       = pwdata[0];
        RegSelHeld:  cfg_d.select_held_low = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegByteSwap: prdata = {31'b0, cfg_q.byte_swap};
      RegSelHeld:  prdata = {31'b0, cfg_q.select_held_low};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- front end: classify ----
  lcdbm_front u_front (
    .item_i (item_i),
    .cfg_i  (cfg_q),
    .keep_o (keep),
    .desc_o (desc)
  );

  // Dropped kinds never enter the queue but are still taken while not full.
  assign full = q_full;

  lcdbm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push & keep),
    .wdata_i (desc),
    .full_o  (q_full),
    .rd_i    (head_pop),
    .empty_o (q_empty),
    .rdata_o (head)
  );

  // ---- back end: strobe sequencer and result register ----
  lcdbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (~q_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

endmodule

>>> hw/rtl/lcdbm_front.sv
// Front end: classifies an item into a bus cycle descriptor.
module lcdbm_front import lcdbm_pkg::*; (
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     keep_o,
  output desc_t    desc_o
);

  logic [7:0]  b0, b1, b2;
  logic [15:0] pix;
  logic [15:0] rword;
  logic [1:0]  nbytes;

  assign b0 = item_i.panel_bytes[23:16];
  assign b1 = item_i.panel_bytes[15:8];
  assign b2 = item_i.panel_bytes[7:0];

  assign pix = {b0 & RedMask, 8'h00} | {5'b0, b1 & GreenMask, 3'b0} | {11'b0, b2[7:3]};

  always_comb begin
    case (item_i.read_format)
      FmtWord: begin
        nbytes = 2'd2;
        rword  = cfg_i.byte_swap ? {b2, b1} : {b1, b2};
      end
      FmtPixel: begin
        nbytes = 2'd3;
        rword  = cfg_i.byte_swap ? {pix[7:0], pix[15:8]} : pix;
      end
      default: begin
        nbytes = 2'd1;
        rword  = {8'h00, b2};
      end
    endcase
  end

  always_comb begin
    desc_o = '0;
    keep_o = 1'b1;
    case (item_i.kind)
      KindCmd, KindData: begin
        desc_o.rs    = item_i.kind[0];
        desc_o.total = item_i.wide ? 5'd2 : 5'd1;
        if (item_i.wide) begin
          desc_o.byte0 = cfg_i.byte_swap ? item_i.word_value[7:0] : item_i.word_value[15:8];
          desc_o.byte1 = cfg_i.byte_swap ? item_i.word_value[15:8] : item_i.word_value[7:0];
        end else begin
          desc_o.byte0 = item_i.word_value[7:0];
        end
      end
      KindRead: begin
        desc_o.is_read = 1'b1;
        desc_o.rs      = 1'b1;
        desc_o.dummies = item_i.dummy_reads;
        desc_o.total   = {1'b0, item_i.dummy_reads} + {3'b0, nbytes};
        desc_o.rword   = rword;
      end
      default: keep_o = 1'b0;
    endcase
    desc_o.rel = item_i.closes & ~cfg_i.select_held_low;
  end

endmodule

>>> hw/rtl/lcdbm_queue.sv
// Descriptor queue between the front and back ends.
module lcdbm_queue import lcdbm_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  desc_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  empty_o,
  output desc_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/lcdbm_back.sv
// Back end: steps through the bus cycles of one descriptor into the result register.
module lcdbm_back import lcdbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  desc_t     head_i,
  output logic      head_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, cyc;
  logic       is_last, load, taken;

  assign is_last = (cnt_q == head_i.total - 5'd1);
  assign taken   = pop_i & out_valid_q;
  assign load    = head_valid_i & (~out_valid_q | taken);

  always_comb begin
    cyc                 = '0;
    cyc.register_select = head_i.rs;
    cyc.select_active   = 1'b1;  // every cycle lies inside an open transaction
    cyc.last            = is_last;
    cyc.released        = is_last & head_i.rel;
    if (!head_i.is_read) begin
      cyc.cycle_kind = CycWrite;
      cyc.bus_byte   = (cnt_q == 5'd0) ? head_i.byte0 : head_i.byte1;
    end else if (cnt_q < {1'b0, head_i.dummies}) begin
      cyc.cycle_kind = CycDummy;
    end else begin
      cyc.cycle_kind = CycRead;
      cyc.read_valid = is_last;
      cyc.read_word  = is_last ? head_i.rword : 16'h0000;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~taken;
    head_pop_o  = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        cnt_d      = '0;
        head_pop_o = 1'b1;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cyc;
    end
  end

  assign empty_o  = ~out_valid_q;
  assign result_o = out_q;

endmodule

>>> hw/rtl/lcdbm_checker.sv
// Port-level checker for the LCD bus master, with its bind.
`include "parallel_lcd_bus_master_assert.svh"

module lcdbm_checker import lcdbm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t result_o
);

  `LCDBM_ASSERT_NEXT(a_result_holds, clk_i, rst_ni,
    !empty && !pop, !empty && $stable(result_o), "stalled result changed")
  `LCDBM_ASSERT_IMPL(a_select_on, clk_i, rst_ni,
    !empty, result_o.select_active, "strobe outside open transaction")
  `LCDBM_ASSERT_IMPL(a_rvalid_last, clk_i, rst_ni,
    !empty && result_o.read_valid,
    result_o.last && (result_o.cycle_kind == CycRead),
    "read result not on last read strobe")
  `LCDBM_ASSERT_IMPL(a_no_drive_on_read, clk_i, rst_ni,
    !empty && (result_o.cycle_kind != CycWrite), result_o.bus_byte == 8'h00,
    "data pins driven on read strobe")
  `LCDBM_ASSERT(a_release_last, clk_i, rst_ni,
    empty || !result_o.released || result_o.last, "release before final strobe")

endmodule

bind parallel_lcd_bus_master lcdbm_checker u_checker (.*);

>>> verif/lcdbm_strobe_checker.sv
// Bus strobe predictor and scoreboard for the parallel LCD bus master.
`timescale 1ns / 100ps

module lcdbm_strobe_checker import lcdbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic             full,
  input  in_item_t         item_i,
  input  logic             empty,
  input  logic             pop,
  input  out_item_t        result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      strobes_o,
  output int unsigned      reads_o
);

  // mode copy, written by the config port
  logic        swap_mode;
  logic        held_select;

  out_item_t   strobe_q[$];
  int unsigned fails;
  int unsigned strobes_seen;
  int unsigned reads_seen;

  task automatic queue_strobe(input out_item_t s, input logic fin, input logic closes);
    s.last     = fin;
    s.released = fin & closes & ~held_select;
    strobe_q.push_back(s);
  endtask

  // Expand one item into the strobes it puts on the pins.
  task automatic predict_strobes(input in_item_t it);
    out_item_t   s;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] rd_word;
    int          nb;
    logic        fin;
    s       = '0;
    b0      = '0;
    b1      = '0;
    b2      = '0;
    rd_word = '0;
    nb      = 1;
    s.select_active = 1'b1;
    case (it.kind)
      KindCmd, KindData: begin
        s.register_select = (it.kind == KindData);
        s.cycle_kind = CycWrite;
        if (it.wide) begin
          s.bus_byte = swap_mode ? it.word_value[7:0] : it.word_value[15:8];
          queue_strobe(s, 1'b0, it.closes);
          s.bus_byte = swap_mode ? it.word_value[15:8] : it.word_value[7:0];
          queue_strobe(s, 1'b1, it.closes);
        end else begin
          s.bus_byte = it.word_value[7:0];
          queue_strobe(s, 1'b1, it.closes);
        end
      end
      KindRead: begin
        // first byte read sits in the top used byte of panel_bytes
        case (it.read_format)
          FmtWord: begin
            nb = 2;
            b0 = it.panel_bytes[15:8];
            b1 = it.panel_bytes[7:0];
            rd_word = swap_mode ? {b1, b0} : {b0, b1};
          end
          FmtPixel: begin
            nb = 3;
            b0 = it.panel_bytes[23:16];
            b1 = it.panel_bytes[15:8];
            b2 = it.panel_bytes[7:0];
            rd_word = {b0 & RedMask, 8'h00} | {5'b0, b1 & GreenMask, 3'b0}
                    | {8'h00, b2 >> 3};
            if (swap_mode) rd_word = {rd_word[7:0], rd_word[15:8]};
          end
          default: begin
            nb = 1;
            rd_word = {8'h00, it.panel_bytes[7:0]};
          end
        endcase
        s.register_select = 1'b1;
        s.cycle_kind = CycDummy;
        for (int i = 0; i < it.dummy_reads; i++) queue_strobe(s, 1'b0, it.closes);
        s.cycle_kind = CycRead;
        for (int i = 0; i < nb; i++) begin
          fin = (i == nb - 1);
          s.read_word  = fin ? rd_word : 16'h0000;
          s.read_valid = fin;
          queue_strobe(s, fin, it.closes);
        end
      end
      default: ;  // spare kind: dropped, no strobes, no state change
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_strobe(input out_item_t got);
    out_item_t want;
    if (strobe_q.size() == 0) begin
      $error("strobe: none expected, got 0x%0h", got);
      fails++;
    end else begin
      want = strobe_q.pop_front();
      check_field("register_select", 32'(want.register_select), 32'(got.register_select));
      check_field("cycle_kind", 32'(want.cycle_kind), 32'(got.cycle_kind));
      check_field("bus_byte", 32'(want.bus_byte), 32'(got.bus_byte));
      check_field("select_active", 32'(want.select_active), 32'(got.select_active));
      check_field("read_word", 32'(want.read_word), 32'(got.read_word));
      check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
      check_field("released", 32'(want.released), 32'(got.released));
      check_field("last", 32'(want.last), 32'(got.last));
      if (want.read_valid) reads_seen++;
    end
    strobes_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_mode    = 1'b0;
      held_select  = 1'b0;
      fails        = 0;
      strobes_seen = 0;
      reads_seen   = 0;
      strobe_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[AddrW-1:2] == RegByteSwap) swap_mode = pwdata[0];
        else if (paddr[AddrW-1:2] == RegSelHeld) held_select = pwdata[0];
      end
      if (push && !full) predict_strobes(item_i);
      if (pop && !empty) check_strobe(result_o);
    end
    fail_count_o <= fails;
    pending_o    <= strobe_q.size();
    strobes_o    <= strobes_seen;
    reads_o      <= reads_seen;
  end

endmodule

>>> verif/tb_top.sv
// Stimulus and verdict for the parallel LCD bus master testbench.
`timescale 1ns / 100ps

module tb_top;
  import lcdbm_pkg::*;

  // Codes the package leaves without a name.
  localparam logic [1:0] KindNone = 2'd3;  // dropped by the block
  localparam logic [1:0] FmtSpare = 2'd3;  // reads one byte
  // At least this many items per random phase; four phases, one per mode setting.
  localparam int unsigned PhaseItems = 62;
  // Idle time after the last strobe before touching config.
  localparam int unsigned SettleCycles = QueueDepthDef + 8;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  in_item_t         item_i;
  logic             empty;
  logic             pop;
  out_item_t        result_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      strobes_checked;
  int unsigned      reads_checked;
  int unsigned      items_sent;
  // set for a phase with no idling on either side
  logic             steady;

  parallel_lcd_bus_master u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lcdbm_strobe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .strobes_o    (strobes_checked),
    .reads_o      (reads_checked)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop, set well past the worst legal run.
  initial begin
    #1_200_000;
    $display("tb: failure");
    $finish;
  end

  // Idle length: mostly none, often a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Result side: pop stalls at random outside the steady phase. Values are sampled right after the
  // edge, so everything read there is the pre-edge state.
  initial begin
    int unsigned hold;
    hold = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0 && !steady) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        hold = gap_len();
      end
    end
  end

  function automatic in_item_t mk_item(input logic [1:0] kind, input logic [15:0] wv,
                                       input logic wide, input logic [1:0] fmt,
                                       input logic [3:0] dummies, input logic [23:0] panel,
                                       input logic closes);
    in_item_t it;
    it.kind        = kind;
    it.word_value  = wv;
    it.wide        = wide;
    it.read_format = fmt;
    it.dummy_reads = dummies;
    it.panel_bytes = panel;
    it.closes      = closes;
    return it;
  endfunction

  // One item of a panel transaction: a command usually opens it, data
  // writes and reads follow, and the tail usually closes it. A few spare
  // kinds and stray closes keep some sequences broken.
  function automatic in_item_t burst_item(input logic first, input logic tail);
    in_item_t    it;
    int unsigned r;
    it.word_value  = 16'($urandom);
    it.wide        = 1'($urandom);
    it.read_format = 2'($urandom);
    it.panel_bytes = 24'($urandom);
    // short dummy runs mostly, the full range now and then
    it.dummy_reads = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (r < 5) it.kind = KindNone;
    else if (first && r < 85) it.kind = KindCmd;
    else if (r < 55) it.kind = KindData;
    else if (r < 90) it.kind = KindRead;
    else it.kind = KindCmd;
    it.closes = tail ? 1'($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // Offer one item after a random gap and hold it until full is low at an
  // edge. push stays high into the next item when there is no gap.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Wait for every predicted strobe, then let the block settle. The first
  // edge lets the checker count an item taken at the current edge.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both mode registers back to back; psel stays high between the
  // two transfers so no signal gets two updates in one step.
  task automatic set_config(input logic swap, input logic held);
    logic [AddrW-1:0] addrs [2];
    logic [31:0]      vals  [2];
    addrs[0] = AddrW'({RegByteSwap, 2'b00});
    addrs[1] = AddrW'({RegSelHeld, 2'b00});
    vals[0]  = {31'd0, swap};
    vals[1]  = {31'd0, held};
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addrs[i];
      pwdata  <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned blen;
    items_sent = 0;
    steady     = 1'b0;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, plain mode: edge values, every kind and format, ignored
    // fields at their extremes, the spare kind and the spare format.
    set_config(1'b0, 1'b0);
    send_item(mk_item(KindCmd,  16'h002A, 1'b0, FmtSpare, 4'd15, 24'hFFFFFF, 1'b0));
    send_item(mk_item(KindData, 16'hFFFF, 1'b1, FmtPixel, 4'd15, 24'hFFFFFF, 1'b0));
    send_item(mk_item(KindData, 16'h0000, 1'b1, FmtByte,  4'd0,  24'h000000, 1'b0));
    // narrow write drops the high byte
    send_item(mk_item(KindData, 16'hFF00, 1'b0, FmtWord,  4'd3,  24'h123456, 1'b1));
    send_item(mk_item(KindCmd,  16'hA55A, 1'b1, FmtByte,  4'd0,  24'h000000, 1'b0));
    send_item(mk_item(KindRead, 16'hFFFF, 1'b1, FmtByte,  4'd0,  24'hFFFFA5, 1'b0));
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtWord,  4'd1,  24'h00BEEF, 1'b0));
    // longest item: all dummies plus a packed pixel
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtPixel, 4'd15, 24'hFFFFFF, 1'b0));
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtPixel, 4'd0,  24'h000000, 1'b1));
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtSpare, 4'd2,  24'h123456, 1'b0));
    // spare kind: taken and dropped, closes has no effect
    send_item(mk_item(KindNone, 16'hFFFF, 1'b1, FmtPixel, 4'd15, 24'hFFFFFF, 1'b1));
    send_item(mk_item(KindRead, 16'hFFFF, 1'b1, FmtWord,  4'd0,  24'h00FFFF, 1'b1));
    send_item(mk_item(KindCmd,  16'h0000, 1'b0, FmtByte,  4'd0,  24'h000000, 1'b1));
    drain();

    // Directed, swapped bytes with select held: reversed write order,
    // low-first word read, swapped pixel, close without release.
    set_config(1'b1, 1'b1);
    send_item(mk_item(KindCmd,  16'h1234, 1'b1, FmtByte,  4'd0,  24'h000000, 1'b0));
    send_item(mk_item(KindData, 16'hABCD, 1'b1, FmtByte,  4'd0,  24'h000000, 1'b0));
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtWord,  4'd3,  24'h00CAFE, 1'b0));
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtPixel, 4'd1,  24'h8F4C21, 1'b1));
    send_item(mk_item(KindRead, 16'h0000, 1'b0, FmtByte,  4'd0,  24'h0000FF, 1'b1));
    send_item(mk_item(KindNone, 16'h0000, 1'b0, FmtByte,  4'd0,  24'h000000, 1'b0));
    send_item(mk_item(KindData, 16'h005A, 1'b0, FmtByte,  4'd0,  24'h000000, 1'b1));
    drain();

    // Random transactions, one phase per mode setting; the third phase
    // runs with no idling at all.
    for (int p = 0; p < 4; p++) begin
      steady = (p == 2);
      set_config(p[0], p[1]);
      sent = 0;
      while (sent < PhaseItems) begin
        blen = $urandom_range(1, 6);
        for (int k = 0; k < blen; k++) begin
          send_item(burst_item(k == 0, k == blen - 1));
          sent++;
        end
      end
      drain();
    end
    steady = 1'b0;

    $display("run: %0d items under four mode settings, %0d strobes checked, %0d reads",
             items_sent, strobes_checked, reads_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
